>>> rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants for the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned FRAME_W  = 15;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_TEST  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    clr_wr;
    logic    ptr_clr;
    logic    scan_rd;
    logic    req_rd;
    logic    load_req;
    logic    fin;
    status_e fin_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic words_zero;
    logic idx_oor;
    logic is_alloc;
    logic scan_issue;
    logic word_full;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/fba_if.sv
// ----------------------------------------------------------------------------
// fba interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fba_req_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::OP_W-1:0]      op;
  logic [fba_pkg::FRAME_W-1:0]   frame_index;

  modport source (output valid, output op, output frame_index, input ready);
  modport sink   (input valid, input op, input frame_index, output ready);
endinterface

interface fba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fba_pkg::FRAME_W-1:0]    result_frame;
  logic                           frame_was_used;
  logic [fba_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output result_frame, output frame_was_used,
                  output status, input ready);
  modport sink   (input valid, input result_frame, input frame_was_used,
                  input status, output ready);
endinterface

interface fba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::CFG_W-1:0]   frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

>>> rtl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer for bitmap clearing, first-fit scan and read-modify-write.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  fba_pkg::sts_t     sts_i,
  output fba_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e               state_q, state_d;
  logic                 rv_q, rv_d;
  fba_pkg::status_e     stat_q, stat_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    rv_d    = 1'b0;
    stat_d  = stat_q;
    cmd_o   = '0;
    cmd_o.fin_status = stat_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_alloc) begin
          if (sts_i.words_zero) begin
            stat_d  = fba_pkg::STAT_FULL;
            state_d = S_FIN;
          end else begin
            cmd_o.ptr_clr = 1'b1;
            state_d       = S_SCAN;
          end
        end else if (sts_i.idx_oor) begin
          stat_d  = fba_pkg::STAT_RANGE;
          state_d = S_FIN;
        end else begin
          cmd_o.req_rd = 1'b1;
          stat_d       = fba_pkg::STAT_OK;
          state_d      = S_FIN;
        end
      end
      S_SCAN: begin
        if (rv_q && !sts_i.word_full) begin
          stat_d  = fba_pkg::STAT_OK;
          state_d = S_FIN;
        end else if (!rv_q && !sts_i.scan_issue) begin
          stat_d  = fba_pkg::STAT_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.scan_rd = sts_i.scan_issue;
          rv_d          = sts_i.scan_issue;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      rv_q    <= 1'b0;
      stat_q  <= fba_pkg::STAT_OK;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      stat_q  <= stat_d;
    end
  end

endmodule

>>> rtl/fba_dp.sv
// ----------------------------------------------------------------------------
// fba_dp
// Bitmap memory, scan pointer, free-bit encoder and response register.
// ----------------------------------------------------------------------------
module fba_dp #(
  parameter int unsigned MAX_FRAMES = 32768,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fba_pkg::cmd_t                   cmd_i,
  output fba_pkg::sts_t                   sts_o,
  input  logic [fba_pkg::OP_W-1:0]        req_op_i,
  input  logic [fba_pkg::FRAME_W-1:0]     req_idx_i,
  input  logic                            cfg_wr_i,
  input  logic [fba_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            rsp_ready_i,
  output logic                            rsp_valid_o,
  output logic [fba_pkg::FRAME_W-1:0]     rsp_frame_o,
  output logic                            rsp_was_o,
  output logic [fba_pkg::STATUS_W-1:0]    rsp_status_o
);

  localparam int unsigned NUM_WORDS = MAX_FRAMES / WORD_BITS;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned WC_W      = $clog2(NUM_WORDS + 1);
  localparam int unsigned FN_W      = AW + BIT_W;
  localparam int unsigned FW        = fba_pkg::FRAME_W;

  logic [fba_pkg::CFG_W-1:0]   cfg_q;
  fba_pkg::op_e                op_q;
  logic [FW-1:0]               idx_q;
  logic [WC_W-1:0]             ptr_q, ptr_d;
  logic [WORD_BITS-1:0]        mem_q [NUM_WORDS];
  logic [WORD_BITS-1:0]        rdata_q;
  logic [AW-1:0]               raddr_q;

  logic                        out_valid_q;
  logic [FW-1:0]               out_frame_q;
  logic                        out_was_q;
  fba_pkg::status_e            out_status_q;

  logic [31:0]                 fic_ext, fic_sat;
  logic [WC_W-1:0]             words;
  logic [FW-1:0]               idx_word;
  logic [BIT_W-1:0]            free_pos, bit_sel;
  logic [WORD_BITS-1:0]        bit_mask, upd_word;
  logic                        rd_en, wr_en, fin_wr;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [WORD_BITS-1:0]        wr_data;
  logic [FN_W-1:0]             found_frame;
  logic [FW-1:0]               fin_frame;
  logic                        fin_was;

  // active word count
  assign fic_ext  = 32'(cfg_q);
  assign fic_sat  = (fic_ext > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : fic_ext;
  assign words    = WC_W'(fic_sat >> BIT_W);
  assign idx_word = idx_q >> BIT_W;

  // lowest clear bit of the word just read
  always_comb begin
    free_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!rdata_q[b]) begin
        free_pos = BIT_W'(b);
      end
    end
  end

  assign bit_sel     = (op_q == fba_pkg::OP_ALLOC) ? free_pos : idx_q[BIT_W-1:0];
  assign bit_mask    = WORD_BITS'(1) << bit_sel;
  assign found_frame = {raddr_q, free_pos};

  always_comb begin
    fin_frame = idx_q;
    fin_was   = 1'b0;
    fin_wr    = 1'b0;
    upd_word  = rdata_q;
    case (cmd_i.fin_status)
      fba_pkg::STAT_OK: begin
        case (op_q)
          fba_pkg::OP_ALLOC: begin
            fin_frame = FW'(found_frame);
            upd_word  = rdata_q | bit_mask;
            fin_wr    = 1'b1;
          end
          fba_pkg::OP_MARK: begin
            fin_was  = |(rdata_q & bit_mask);
            upd_word = rdata_q | bit_mask;
            fin_wr   = 1'b1;
          end
          fba_pkg::OP_FREE: begin
            fin_was  = |(rdata_q & bit_mask);
            upd_word = rdata_q & ~bit_mask;
            fin_wr   = 1'b1;
          end
          default: begin
            fin_was = |(rdata_q & bit_mask);
          end
        endcase
      end
      fba_pkg::STAT_FULL: begin
        fin_frame = '0;
      end
      default: begin
        fin_frame = idx_q;
      end
    endcase
  end

  // memory port selection
  assign rd_en   = cmd_i.scan_rd || cmd_i.req_rd;
  assign rd_addr = cmd_i.scan_rd ? ptr_q[AW-1:0] : AW'(idx_word);
  assign wr_en   = cmd_i.clr_wr || (cmd_i.fin && fin_wr);
  assign wr_addr = cmd_i.clr_wr ? ptr_q[AW-1:0] : raddr_q;
  assign wr_data = cmd_i.clr_wr ? '0 : upd_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.clr_wr || cmd_i.scan_rd) begin
      ptr_d = ptr_q + WC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= fba_pkg::CFG_W'(32768);
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (cfg_wr_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= fba_pkg::op_e'(req_op_i);
      idx_q <= req_idx_i;
    end
    if (cmd_i.fin) begin
      out_frame_q  <= fin_frame;
      out_was_q    <= fin_was;
      out_status_q <= cmd_i.fin_status;
    end
  end

  assign sts_o.clr_last   = (ptr_q == WC_W'(NUM_WORDS - 1));
  assign sts_o.words_zero = (words == '0);
  assign sts_o.idx_oor    = (32'(idx_word) >= 32'(words));
  assign sts_o.is_alloc   = (op_q == fba_pkg::OP_ALLOC);
  assign sts_o.scan_issue = (ptr_q < words);
  assign sts_o.word_full  = &rdata_q;
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign rsp_frame_o  = out_frame_q;
  assign rsp_was_o    = out_was_q;
  assign rsp_status_o = out_status_q;

endmodule

>>> rtl/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a used-bit map in on-chip memory.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is cleared one word per cycle, all
// MAX_FRAMES/WORD_BITS words of it (1024 by default); requests are held off
// until it finishes, configuration writes are taken at any time. Requests
// are served one at a time. Mark and free take a single read-modify-write of
// one bitmap word, test a single read. Allocate scans the active words from
// word zero through the single read port at one word per cycle and stops at
// the first word with a clear bit; the active words number
// frames_in_use/WORD_BITS, at most MAX_FRAMES/WORD_BITS. With no active word
// it reports full without reading the bitmap. The result sits in an output
// register until taken, and the next request is accepted only after that
// register has been loaded.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
  parameter int unsigned MAX_FRAMES = 32768,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fba_req_if.sink      req_i,
  fba_rsp_if.source    rsp_o,
  fba_cfg_if.sink      cfg_i
);

  fba_pkg::cmd_t cmd;
  fba_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  fba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fba_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_op_i     (req_i.op),
    .req_idx_i    (req_i.frame_index),
    .cfg_wr_i     (cfg_i.valid && cfg_i.ready),
    .cfg_data_i   (cfg_i.frames_in_use),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_frame_o  (rsp_o.result_frame),
    .rsp_was_o    (rsp_o.frame_was_used),
    .rsp_status_o (rsp_o.status)
  );

`ifndef SYNTHESIS
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while one is in progress");

  a_full_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin && cmd.fin_status == fba_pkg::STAT_FULL |=>
      rsp_o.valid && rsp_o.result_frame == '0 && !rsp_o.frame_was_used)
    else $error("full status with nonzero frame");

  a_clear_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !cmd.scan_rd && !cmd.req_rd && !cmd.fin && !req_i.ready)
    else $error("memory access during clearing pass");
`endif

endmodule

>>> tb/frame_bitmap_allocator_tb.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_tb
// Self-checking testbench for the first-fit frame bitmap allocator. A
// directed table covers reset state, the field extremes, every operation,
// full and out-of-range results and the register extremes. Randomized phases
// at several frame counts follow. Every response is checked field by field
// against the row's expected result or else a bitmap model, with random idling
// on both sides and two long response hold-offs that back up the requests.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  localparam int WORD_BITS     = 32;
  localparam int NUM_WORDS     = 1024;
  localparam int MAX_FRAMES    = 32768;
  localparam int STALL_LIMIT   = 6000;
  localparam int DIRECTED_ROWS = 26;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    op_e         op;
    logic [15:0] arg;
    logic        typed;
    logic [14:0] frame;
    logic        used;
    status_e     status;
  } stim_row_t;

  typedef struct packed {
    logic [14:0] frame;
    logic        was_used;
    status_e     status;
  } frame_result_t;

  logic clk;
  logic rst_n;

  fba_req_if req_bus ();
  fba_rsp_if rsp_bus ();
  fba_cfg_if cfg_bus ();

  frame_bitmap_allocator u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  logic [31:0]   used_words [NUM_WORDS];
  logic [15:0]   managed_frames;
  frame_result_t pending_results [$];
  int            held_frames [$];
  int unsigned   mismatches;
  int unsigned   idle_cycles;
  int unsigned   hold_rsp_cycles;
  int unsigned   sent;
  int unsigned   op_count [4];
  int unsigned   full_count;
  int unsigned   range_count;
  int unsigned   cfg_writes;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_REQ, OP_ALLOC, 16'd0,     1'b1, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_ALLOC, 16'd0,     1'b1, 15'd1,     1'b0, STAT_OK},
    '{ROW_REQ, OP_TEST,  16'd0,     1'b1, 15'd0,     1'b1, STAT_OK},
    '{ROW_REQ, OP_TEST,  16'd32767, 1'b1, 15'd32767, 1'b0, STAT_OK},
    '{ROW_REQ, OP_MARK,  16'd32767, 1'b1, 15'd32767, 1'b0, STAT_OK},
    '{ROW_REQ, OP_TEST,  16'd32767, 1'b1, 15'd32767, 1'b1, STAT_OK},
    '{ROW_REQ, OP_FREE,  16'd0,     1'b1, 15'd0,     1'b1, STAT_OK},
    '{ROW_REQ, OP_FREE,  16'd0,     1'b1, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_ALLOC, 16'd32767, 1'b1, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_MARK,  16'd2,     1'b1, 15'd2,     1'b0, STAT_OK},
    '{ROW_REQ, OP_ALLOC, 16'd0,     1'b1, 15'd3,     1'b0, STAT_OK},
    '{ROW_REQ, OP_MARK,  16'd21845, 1'b0, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_TEST,  16'd10922, 1'b0, 15'd0,     1'b0, STAT_OK},
    '{ROW_CFG, OP_ALLOC, 16'd32,    1'b0, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_TEST,  16'd32,    1'b1, 15'd32,    1'b0, STAT_RANGE},
    '{ROW_REQ, OP_MARK,  16'd32767, 1'b1, 15'd32767, 1'b0, STAT_RANGE},
    '{ROW_REQ, OP_FREE,  16'd31,    1'b1, 15'd31,    1'b0, STAT_OK},
    '{ROW_REQ, OP_ALLOC, 16'd0,     1'b1, 15'd4,     1'b0, STAT_OK},
    '{ROW_CFG, OP_ALLOC, 16'd31,    1'b0, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_ALLOC, 16'd0,     1'b1, 15'd0,     1'b0, STAT_FULL},
    '{ROW_REQ, OP_TEST,  16'd0,     1'b1, 15'd0,     1'b0, STAT_RANGE},
    '{ROW_CFG, OP_ALLOC, 16'd0,     1'b0, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_MARK,  16'd5,     1'b1, 15'd5,     1'b0, STAT_RANGE},
    '{ROW_CFG, OP_ALLOC, 16'd65535, 1'b0, 15'd0,     1'b0, STAT_OK},
    '{ROW_REQ, OP_TEST,  16'd32767, 1'b1, 15'd32767, 1'b1, STAT_OK},
    '{ROW_REQ, OP_FREE,  16'd32767, 1'b1, 15'd32767, 1'b1, STAT_OK}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // frames reachable under the current register, whole words only
  function automatic int active_frames();
    int n;
    n = (int'(managed_frames) > MAX_FRAMES) ? MAX_FRAMES : int'(managed_frames);
    return (n / WORD_BITS) * WORD_BITS;
  endfunction

  function automatic frame_result_t serve_request(op_e op, logic [14:0] idx);
    frame_result_t res;
    int lim;
    int w;
    int b;
    bit found;
    lim = active_frames();
    res = '0;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      for (w = 0; w < lim / WORD_BITS && !found; w++) begin
        if (used_words[w] != '1) begin
          for (b = 0; b < WORD_BITS && !found; b++) begin
            if (!used_words[w][b]) begin
              used_words[w][b] = 1'b1;
              res.frame = 15'(w * WORD_BITS + b);
              found = 1'b1;
            end
          end
        end
      end
      if (!found) res.status = STAT_FULL;
    end else begin
      res.frame = idx;
      if (int'(idx) >= lim) begin
        res.status = STAT_RANGE;
      end else begin
        res.was_used = used_words[idx[14:5]][idx[4:0]];
        if (op == OP_MARK) used_words[idx[14:5]][idx[4:0]] = 1'b1;
        else if (op == OP_FREE) used_words[idx[14:5]][idx[4:0]] = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic offer_request(op_e op, logic [14:0] idx, logic typed, frame_result_t typed_res);
    int gap;
    frame_result_t res;
    gap = ((sent / 25) % 3 == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.op          <= op;
    req_bus.frame_index <= idx;
    do @(posedge clk); while (!req_bus.ready);
    res = serve_request(op, idx);
    pending_results.push_back(typed ? typed_res : res);
    sent++;
    op_count[op]++;
    if (res.status == STAT_FULL) full_count++;
    if (res.status == STAT_RANGE) range_count++;
    if (res.status == STAT_OK && (op == OP_ALLOC || op == OP_MARK)) begin
      held_frames.push_back(int'(res.frame));
      if (held_frames.size() > 64) void'(held_frames.pop_front());
    end
  endtask

  // register write only once every response is back
  task automatic write_frames_in_use(logic [15:0] value);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.frames_in_use <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid  <= 1'b0;
    managed_frames = value;
    cfg_writes++;
  endtask

  initial begin : stimulus
    stim_row_t     row;
    frame_result_t want;
    logic [15:0]   phase_sizes [8];
    logic [15:0]   sz;
    logic [14:0]   idx;
    op_e           op;
    int            pick;
    int            lim;
    int            slot;
    int            near;
    int            total_bad;

    req_bus.valid         = 1'b0;
    req_bus.op            = OP_ALLOC;
    req_bus.frame_index   = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.frames_in_use = '0;
    rst_n                 = 1'b0;
    managed_frames        = 16'd32768;
    hold_rsp_cycles       = 0;
    foreach (used_words[i]) used_words[i] = '0;
    phase_sizes = '{16'd64, 16'd100, 16'd32768, 16'd288, 16'd32, 16'd65535, 16'd0, 16'd17};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_frames_in_use(row.arg);
      end else begin
        want = '{frame: row.frame, was_used: row.used, status: row.status};
        offer_request(row.op, row.arg[14:0], row.typed, want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      sz = (p == 6) ? 16'($urandom_range(33, 4095)) : phase_sizes[p];
      write_frames_in_use(sz);
      if (p == 2 || p == 5) hold_rsp_cycles = 300;
      repeat ((p == 7) ? 20 : 80) begin
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? OP_ALLOC : (pick < 60) ? OP_MARK : (pick < 85) ? OP_FREE : OP_TEST;
        lim = active_frames();
        pick = $urandom_range(0, 9);
        if (op == OP_FREE && held_frames.size() != 0 && pick < 6) begin
          slot = $urandom_range(0, held_frames.size() - 1);
          idx = 15'(held_frames[slot]);
          held_frames.delete(slot);
        end else if (pick < 8 && lim > 0) begin
          idx = 15'($urandom_range(0, lim - 1));
        end else if (pick == 8) begin
          near = lim + int'($urandom_range(0, 3)) - 2;
          if (near < 0) near = 0;
          if (near > MAX_FRAMES - 1) near = MAX_FRAMES - 1;
          idx = 15'(near);
        end else begin
          idx = 15'($urandom);
        end
        offer_request(op, idx, 1'b0, '0);
      end
    end

    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    total_bad = mismatches + pending_results.size();
    $display("covered %0d requests: %0d allocate, %0d mark, %0d free, %0d test",
             sent, op_count[OP_ALLOC], op_count[OP_MARK], op_count[OP_FREE],
             op_count[OP_TEST]);
    $display("%0d register writes, %0d full and %0d out-of-range results, %0d mismatches",
             cfg_writes, full_count, range_count, total_bad);
    if (total_bad == 0) begin
      $display("frame_bitmap_allocator_tb: done, clean");
    end else begin
      $display("frame_bitmap_allocator_tb: done, errors");
    end
    $finish;
  end

  // response side: random stalls, quiet stretches and long hold-offs
  initial begin : rsp_side
    int stall;
    int unsigned taken;
    rsp_bus.ready = 1'b0;
    taken = 0;
    forever begin
      stall = ((taken / 30) % 3 == 0) ? 0 : $urandom_range(0, 12);
      if (hold_rsp_cycles != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (hold_rsp_cycles) @(posedge clk);
        hold_rsp_cycles = 0;
      end else if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      taken++;
    end
  end

  always @(posedge clk) begin : check_rsp
    frame_result_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: frame %0d used %0b status %0d",
                   rsp_bus.result_frame, rsp_bus.frame_was_used, rsp_bus.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.result_frame !== want.frame || rsp_bus.frame_was_used !== want.was_used ||
            rsp_bus.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected frame %0d used %0b status %0d, got %0d %0b %0d",
                     want.frame, want.was_used, want.status, rsp_bus.result_frame,
                     rsp_bus.frame_was_used, rsp_bus.status);
        end
      end
    end
  end

  // no handshake on any channel for too long
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", idle_cycles);
      $display("frame_bitmap_allocator_tb: done, errors");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    mismatches  = 0;
    sent        = 0;
    full_count  = 0;
    range_count = 0;
    cfg_writes  = 0;
    foreach (op_count[i]) op_count[i] = 0;
  end

endmodule

>>> sim.f
rtl/fba_pkg.sv
rtl/fba_if.sv
rtl/fba_ctrl.sv
rtl/fba_dp.sv
rtl/frame_bitmap_allocator.sv
tb/frame_bitmap_allocator_tb.sv
